FILE: rtl/rlps_pkg.sv
// ----------------------------------------------------------------------------
// rlps_pkg
// Shared types and constants for the LED strip pulse serializer
// ----------------------------------------------------------------------------
package rlps_pkg;

    localparam int DEFAULT_TICK_WIDTH = 8;
    localparam int PIXEL_BITS         = 24;
    localparam int CFG_ADDR_WIDTH     = 4;
    localparam int CFG_DATA_WIDTH     = 32;

    // register indexes
    localparam logic [1:0] REG_BIT_PERIOD     = 2'd0;
    localparam logic [1:0] REG_HIGH_TIME_ONE  = 2'd1;
    localparam logic [1:0] REG_HIGH_TIME_ZERO = 2'd2;
    localparam logic [1:0] REG_TRAILER_BITS   = 2'd3;

    // reset values
    localparam logic [7:0] RST_BIT_PERIOD     = 8'd105;
    localparam logic [7:0] RST_HIGH_TIME_ONE  = 8'd76;
    localparam logic [7:0] RST_HIGH_TIME_ZERO = 8'd28;
    localparam logic [7:0] RST_TRAILER_BITS   = 8'd48;

    // line phase codes
    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_PIXEL   = 2'd1;
    localparam logic [1:0] PH_TRAILER = 2'd2;

    typedef struct packed {
        logic       action;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last_pixel;
    } t_in_item;

    typedef struct packed {
        logic line_level;
        logic can_accept;
        logic pixel_refused;
        logic underrun;
        logic frame_done;
    } t_out_item;

    typedef struct packed {
        logic [7:0] bit_period;
        logic [7:0] high_time_one;
        logic [7:0] high_time_zero;
        logic [7:0] trailer_bits;
    } t_cfg;

endpackage

FILE: rtl/rlps_cfg_regs.sv
// ----------------------------------------------------------------------------
// rlps_cfg_regs
// APB-style register bank holding the pulse timing and trailer length
// ----------------------------------------------------------------------------
module rlps_cfg_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rlps_pkg::CFG_ADDR_WIDTH-1:0] paddr,
    input  logic [rlps_pkg::CFG_DATA_WIDTH-1:0] pwdata,
    output logic [rlps_pkg::CFG_DATA_WIDTH-1:0] prdata,
    output logic                                pready,
    output rlps_pkg::t_cfg                      o_cfg
);

    rlps_pkg::t_cfg r_cfg;
    logic           w_wr;
    logic [1:0]     w_idx;
    logic [7:0]     w_rd;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite & pready;
    assign w_idx  = paddr[rlps_pkg::CFG_ADDR_WIDTH-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bit_period     <= rlps_pkg::RST_BIT_PERIOD;
            r_cfg.high_time_one  <= rlps_pkg::RST_HIGH_TIME_ONE;
            r_cfg.high_time_zero <= rlps_pkg::RST_HIGH_TIME_ZERO;
            r_cfg.trailer_bits   <= rlps_pkg::RST_TRAILER_BITS;
        end else if (w_wr) begin
            case (w_idx)
                rlps_pkg::REG_BIT_PERIOD:     r_cfg.bit_period     <= pwdata[7:0];
                rlps_pkg::REG_HIGH_TIME_ONE:  r_cfg.high_time_one  <= pwdata[7:0];
                rlps_pkg::REG_HIGH_TIME_ZERO: r_cfg.high_time_zero <= pwdata[7:0];
                rlps_pkg::REG_TRAILER_BITS:   r_cfg.trailer_bits   <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            rlps_pkg::REG_BIT_PERIOD:     w_rd = r_cfg.bit_period;
            rlps_pkg::REG_HIGH_TIME_ONE:  w_rd = r_cfg.high_time_one;
            rlps_pkg::REG_HIGH_TIME_ZERO: w_rd = r_cfg.high_time_zero;
            rlps_pkg::REG_TRAILER_BITS:   w_rd = r_cfg.trailer_bits;
            default:                      w_rd = 8'd0;
        endcase
    end

    assign prdata = {{(rlps_pkg::CFG_DATA_WIDTH-8){1'b0}}, w_rd};
    assign o_cfg  = r_cfg;

endmodule

FILE: rtl/rgb_led_pulse_serializer.sv
// ----------------------------------------------------------------------------
// rgb_led_pulse_serializer
// One-wire LED strip encoder: pixels in, per-tick line level and status out
// ----------------------------------------------------------------------------
// Every input transaction is either one clock tick of the line or a pixel
// offer, and yields exactly one result transaction. Unless stalled, one is taken
// per clock cycle; its result sits in the output register from the next
// cycle on. The single path from the state registers through the tick and
// bit counters to the output register sets this rate. The input stalls only
// while a result is held in the output register and the far side stalls.
module rgb_led_pulse_serializer #(
    parameter int TICK_WIDTH = rlps_pkg::DEFAULT_TICK_WIDTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  rlps_pkg::t_in_item                  i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output rlps_pkg::t_out_item                 o_out_data,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rlps_pkg::CFG_ADDR_WIDTH-1:0] paddr,
    input  logic [rlps_pkg::CFG_DATA_WIDTH-1:0] pwdata,
    output logic [rlps_pkg::CFG_DATA_WIDTH-1:0] prdata,
    output logic                                pready
);

    localparam int CW = TICK_WIDTH + 2;
    localparam logic [CW-1:0] TICK_LIMIT = CW'(1) << TICK_WIDTH;

    rlps_pkg::t_cfg      w_cfg;
    rlps_pkg::t_out_item n_out;
    rlps_pkg::t_out_item r_out;
    logic                r_out_valid;
    logic                w_accept;
    logic [CW-1:0]       w_period;

    logic [1:0]            r_phase,      n_phase;
    logic [23:0]           r_shift,      n_shift;
    logic [4:0]            r_bit_idx,    n_bit_idx;
    logic [TICK_WIDTH-1:0] r_tick,       n_tick;
    logic [23:0]           r_held_pix,   n_held_pix;
    logic                  r_held_valid, n_held_valid;
    logic                  r_held_last,  n_held_last;
    logic                  r_send_last,  n_send_last;
    logic [7:0]            r_trl_cnt,    n_trl_cnt;

    logic [TICK_WIDTH-1:0] v_tick_inc;
    logic [5:0]            v_bit_inc;
    logic [7:0]            v_trl_inc;

    rlps_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    function automatic logic level_of(
        input logic [1:0]            phase,
        input logic [23:0]           shift,
        input logic [4:0]            idx,
        input logic [TICK_WIDTH-1:0] tick,
        input rlps_pkg::t_cfg        cfg
    );
        logic       b;
        logic [7:0] ht;
        b  = 1'b0;
        ht = 8'd0;
        if (phase != rlps_pkg::PH_PIXEL || idx >= 5'(rlps_pkg::PIXEL_BITS)) begin
            return 1'b0;
        end
        b  = shift[5'd23 - idx];
        ht = b ? cfg.high_time_one : cfg.high_time_zero;
        return (CW'(tick) < CW'(ht));
    endfunction

    // effective period: zero acts as one, clamped to the tick range
    always_comb begin
        w_period = CW'(w_cfg.bit_period);
        if (w_period == '0) begin
            w_period = CW'(1);
        end
        if (w_period > TICK_LIMIT) begin
            w_period = TICK_LIMIT;
        end
    end

    assign o_in_stall = r_out_valid & i_out_stall;
    assign w_accept   = i_in_valid & ~o_in_stall;

    always_comb begin
        n_phase      = r_phase;
        n_shift      = r_shift;
        n_bit_idx    = r_bit_idx;
        n_tick       = r_tick;
        n_held_pix   = r_held_pix;
        n_held_valid = r_held_valid;
        n_held_last  = r_held_last;
        n_send_last  = r_send_last;
        n_trl_cnt    = r_trl_cnt;
        n_out        = '0;
        v_tick_inc   = '0;
        v_bit_inc    = '0;
        v_trl_inc    = '0;

        if (w_accept) begin
            if (i_in_data.action) begin
                n_out.line_level = level_of(r_phase, r_shift, r_bit_idx, r_tick, w_cfg);
                if (r_held_valid) begin
                    n_out.pixel_refused = 1'b1;
                end else begin
                    n_held_pix   = {i_in_data.green, i_in_data.red, i_in_data.blue};
                    n_held_last  = i_in_data.last_pixel;
                    n_held_valid = 1'b1;
                end
            end else begin
                if (r_phase != rlps_pkg::PH_PIXEL && r_phase != rlps_pkg::PH_TRAILER) begin
                    n_phase = rlps_pkg::PH_IDLE;
                    if (r_held_valid) begin
                        n_shift      = r_held_pix;
                        n_send_last  = r_held_last;
                        n_held_valid = 1'b0;
                        n_held_last  = 1'b0;
                        n_bit_idx    = '0;
                        n_tick       = '0;
                        n_phase      = rlps_pkg::PH_PIXEL;
                    end
                end

                if (n_phase == rlps_pkg::PH_PIXEL) begin
                    n_out.line_level = level_of(n_phase, n_shift, n_bit_idx, n_tick, w_cfg);
                    v_tick_inc = n_tick + 1'b1;
                    if (v_tick_inc == '0 || CW'(v_tick_inc) >= w_period) begin
                        n_tick    = '0;
                        v_bit_inc = {1'b0, n_bit_idx} + 6'd1;
                        if (v_bit_inc >= 6'(rlps_pkg::PIXEL_BITS)) begin
                            n_bit_idx = '0;
                            if (n_send_last) begin
                                n_send_last = 1'b0;
                                n_trl_cnt   = '0;
                                if (w_cfg.trailer_bits == 8'd0) begin
                                    n_out.frame_done = 1'b1;
                                    n_phase          = rlps_pkg::PH_IDLE;
                                end else begin
                                    n_phase = rlps_pkg::PH_TRAILER;
                                end
                            end else if (n_held_valid) begin
                                n_shift      = n_held_pix;
                                n_send_last  = n_held_last;
                                n_held_valid = 1'b0;
                                n_held_last  = 1'b0;
                                n_bit_idx    = '0;
                                n_phase      = rlps_pkg::PH_PIXEL;
                            end else begin
                                n_out.underrun = 1'b1;
                                n_phase        = rlps_pkg::PH_IDLE;
                            end
                        end else begin
                            n_bit_idx = v_bit_inc[4:0];
                        end
                    end else begin
                        n_tick = v_tick_inc;
                    end
                end else if (n_phase == rlps_pkg::PH_TRAILER) begin
                    v_tick_inc = n_tick + 1'b1;
                    if (v_tick_inc == '0 || CW'(v_tick_inc) >= w_period) begin
                        n_tick    = '0;
                        v_trl_inc = n_trl_cnt + 8'd1;
                        if (v_trl_inc >= w_cfg.trailer_bits || v_trl_inc == 8'd0) begin
                            n_trl_cnt        = '0;
                            n_out.frame_done = 1'b1;
                            n_phase          = rlps_pkg::PH_IDLE;
                        end else begin
                            n_trl_cnt = v_trl_inc;
                        end
                    end else begin
                        n_tick = v_tick_inc;
                    end
                end
            end
            n_out.can_accept = ~n_held_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= rlps_pkg::PH_IDLE;
            r_bit_idx    <= '0;
            r_tick       <= '0;
            r_held_valid <= 1'b0;
            r_held_last  <= 1'b0;
            r_send_last  <= 1'b0;
            r_trl_cnt    <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_bit_idx    <= n_bit_idx;
            r_tick       <= n_tick;
            r_held_valid <= n_held_valid;
            r_held_last  <= n_held_last;
            r_send_last  <= n_send_last;
            r_trl_cnt    <= n_trl_cnt;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_shift    <= n_shift;
        r_held_pix <= n_held_pix;
        if (w_accept) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

FILE: rtl/rlps_checker.sv
// ----------------------------------------------------------------------------
// rlps_checker
// Port-level checks for the LED strip pulse serializer
// ----------------------------------------------------------------------------
module rlps_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input rlps_pkg::t_out_item o_out_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // input stalls only behind a stalled result
    a_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a stalled result");

    // every accepted transaction gives a result next cycle
    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_out_valid)
        else $error("accepted transaction produced no result");

    // a refused pixel means the holding buffer stays full
    a_refused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.pixel_refused |-> !o_out_data.can_accept)
        else $error("pixel refused while buffer empty");

    // a tick cannot both end a frame and underrun
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.underrun && o_out_data.frame_done))
        else $error("underrun and frame done together");

endmodule

bind rgb_led_pulse_serializer rlps_checker u_rlps_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

FILE: test/rgb_led_pulse_serializer_tb.sv
// ----------------------------------------------------------------------------
// rgb_led_pulse_serializer_tb
// Self-checking bench for the one-wire LED strip pulse serializer: a short
// table of directed transactions at the reset settings, then random pixel
// frames and ticks under several register settings and idling patterns, each
// result checked against a cycle-free line predictor kept in the bench
// ----------------------------------------------------------------------------
module rgb_led_pulse_serializer_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  CLK_PERIOD  = 20;
    localparam int  TW          = rlps_pkg::DEFAULT_TICK_WIDTH;
    localparam int  HOLD_CYCLES = 300;
    localparam int  TAIL_CYCLES = 10;
    localparam int  CYCLE_LIMIT = 200000;
    localparam int  MAX_REPORTS = 10;

    localparam logic ACT_TICK  = 1'b0;
    localparam logic ACT_PIXEL = 1'b1;

    typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle_mode;

    typedef struct packed {
        rlps_pkg::t_in_item  item;
        logic                typed;
        rlps_pkg::t_out_item want;
    } t_row;

    typedef struct packed {
        logic                typed;
        rlps_pkg::t_out_item want;
    } t_given;

    localparam int DIR_ROWS = 14;
    localparam t_row DIRECTED [DIR_ROWS] = '{
        '{'{ACT_TICK,  8'h00, 8'h00, 8'h00, 1'b0}, 1'b1, '{1'b0, 1'b1, 1'b0, 1'b0, 1'b0}},
        '{'{ACT_PIXEL, 8'hFF, 8'hFF, 8'hFF, 1'b0}, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0}},
        '{'{ACT_PIXEL, 8'h00, 8'h00, 8'h00, 1'b1}, 1'b1, '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0}},
        '{'{ACT_TICK,  8'hFF, 8'hFF, 8'hFF, 1'b1}, 1'b1, '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0}},
        '{'{ACT_PIXEL, 8'h00, 8'h00, 8'h00, 1'b1}, 1'b0, '0},
        '{'{ACT_PIXEL, 8'hA5, 8'h5A, 8'hC3, 1'b0}, 1'b0, '0},
        '{'{ACT_TICK,  8'h00, 8'hFF, 8'h00, 1'b0}, 1'b0, '0},
        '{'{ACT_TICK,  8'hFF, 8'h00, 8'hFF, 1'b1}, 1'b0, '0},
        '{'{ACT_PIXEL, 8'h0F, 8'hF0, 8'h3C, 1'b1}, 1'b0, '0},
        '{'{ACT_TICK,  8'h00, 8'h00, 8'h00, 1'b0}, 1'b0, '0},
        '{'{ACT_TICK,  8'h00, 8'h00, 8'h00, 1'b0}, 1'b0, '0},
        '{'{ACT_PIXEL, 8'hFF, 8'h00, 8'hFF, 1'b0}, 1'b0, '0},
        '{'{ACT_TICK,  8'h00, 8'h00, 8'h00, 1'b0}, 1'b0, '0},
        '{'{ACT_TICK,  8'h00, 8'h00, 8'h00, 1'b0}, 1'b0, '0}
    };

    logic                                clk       = 1'b0;
    logic                                rst_n     = 1'b0;
    logic                                in_valid  = 1'b0;
    rlps_pkg::t_in_item                  in_data   = '0;
    logic                                out_stall = 1'b0;
    logic                                psel      = 1'b0;
    logic                                penable   = 1'b0;
    logic                                pwrite    = 1'b0;
    logic [rlps_pkg::CFG_ADDR_WIDTH-1:0] paddr     = '0;
    logic [rlps_pkg::CFG_DATA_WIDTH-1:0] pwdata    = '0;
    logic                                in_stall;
    logic                                out_valid;
    rlps_pkg::t_out_item                 out_data;
    logic [rlps_pkg::CFG_DATA_WIDTH-1:0] prdata;
    logic                                pready;

    // line predictor state
    rlps_pkg::t_cfg lp_cfg;
    logic [23:0]    lp_shift;
    logic [4:0]     lp_bit_idx;
    logic [TW-1:0]  lp_ticks;
    logic [23:0]    lp_held;
    logic           lp_held_valid;
    logic           lp_held_last;
    logic           lp_send_last;
    logic [1:0]     lp_phase;
    logic [7:0]     lp_trailer_cnt;

    rlps_pkg::t_out_item line_expect [$];
    t_given              given_expect [$];
    int                  fault_count  = 0;
    int                  result_seq   = 0;
    int                  cycle_count  = 0;
    int                  send_pct     = 0;
    int                  recv_pct     = 0;
    bit                  hold_request = 1'b0;
    bit                  starving     = 1'b0;
    int                  pixels_left  = 0;

    rgb_led_pulse_serializer DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic void reset_line();
        lp_cfg         = '{rlps_pkg::RST_BIT_PERIOD, rlps_pkg::RST_HIGH_TIME_ONE,
                           rlps_pkg::RST_HIGH_TIME_ZERO, rlps_pkg::RST_TRAILER_BITS};
        lp_shift       = '0;
        lp_bit_idx     = '0;
        lp_ticks       = '0;
        lp_held        = '0;
        lp_held_valid  = 1'b0;
        lp_held_last   = 1'b0;
        lp_send_last   = 1'b0;
        lp_phase       = rlps_pkg::PH_IDLE;
        lp_trailer_cnt = '0;
    endfunction

    function automatic logic line_now();
        logic       b;
        logic [7:0] ht;
        if (lp_phase != rlps_pkg::PH_PIXEL || lp_bit_idx >= rlps_pkg::PIXEL_BITS) begin
            return 1'b0;
        end
        b  = lp_shift[rlps_pkg::PIXEL_BITS - 1 - lp_bit_idx];
        ht = b ? lp_cfg.high_time_one : lp_cfg.high_time_zero;
        return (int'(lp_ticks) < int'(ht));
    endfunction

    function automatic void load_held();
        lp_shift      = lp_held;
        lp_send_last  = lp_held_last;
        lp_held_valid = 1'b0;
        lp_held_last  = 1'b0;
        lp_bit_idx    = '0;
        lp_ticks      = '0;
        lp_phase      = rlps_pkg::PH_PIXEL;
    endfunction

    function automatic rlps_pkg::t_out_item advance_line(input rlps_pkg::t_in_item it);
        rlps_pkg::t_out_item r;
        int                  period;
        r      = '0;
        period = int'(lp_cfg.bit_period);
        if (period == 0) begin
            period = 1;
        end
        if (period > (1 << TW)) begin
            period = 1 << TW;
        end
        if (it.action == ACT_PIXEL) begin
            r.line_level = line_now();
            if (lp_held_valid) begin
                r.pixel_refused = 1'b1;
            end else begin
                lp_held       = {it.green, it.red, it.blue};
                lp_held_last  = it.last_pixel;
                lp_held_valid = 1'b1;
            end
        end else begin
            if (lp_phase != rlps_pkg::PH_PIXEL && lp_phase != rlps_pkg::PH_TRAILER) begin
                lp_phase = rlps_pkg::PH_IDLE;
                if (lp_held_valid) begin
                    load_held();
                end
            end
            if (lp_phase == rlps_pkg::PH_PIXEL) begin
                r.line_level = line_now();
                lp_ticks     = lp_ticks + 1'b1;
                if (lp_ticks == 0 || lp_ticks >= period) begin
                    lp_ticks   = '0;
                    lp_bit_idx = lp_bit_idx + 1'b1;
                    if (lp_bit_idx >= rlps_pkg::PIXEL_BITS) begin
                        lp_bit_idx = '0;
                        if (lp_send_last) begin
                            lp_send_last   = 1'b0;
                            lp_trailer_cnt = '0;
                            if (lp_cfg.trailer_bits == 0) begin
                                r.frame_done = 1'b1;
                                lp_phase     = rlps_pkg::PH_IDLE;
                            end else begin
                                lp_phase = rlps_pkg::PH_TRAILER;
                            end
                        end else if (lp_held_valid) begin
                            load_held();
                        end else begin
                            r.underrun = 1'b1;
                            lp_phase   = rlps_pkg::PH_IDLE;
                        end
                    end
                end
            end else if (lp_phase == rlps_pkg::PH_TRAILER) begin
                lp_ticks = lp_ticks + 1'b1;
                if (lp_ticks == 0 || lp_ticks >= period) begin
                    lp_ticks       = '0;
                    lp_trailer_cnt = lp_trailer_cnt + 1'b1;
                    if (lp_trailer_cnt >= lp_cfg.trailer_bits || lp_trailer_cnt == 0) begin
                        lp_trailer_cnt = '0;
                        r.frame_done   = 1'b1;
                        lp_phase       = rlps_pkg::PH_IDLE;
                    end
                end
            end
        end
        r.can_accept = !lp_held_valid;
        return r;
    endfunction

    // mostly well-formed frames fed on time, with the odd starved pixel and stray offer
    function automatic rlps_pkg::t_in_item pick_item();
        rlps_pkg::t_in_item it;
        it.action     = ACT_TICK;
        it.red        = 8'($urandom);
        it.green      = 8'($urandom);
        it.blue       = 8'($urandom);
        it.last_pixel = 1'($urandom);
        if (starving && lp_phase == rlps_pkg::PH_IDLE) begin
            starving = 1'b0;
        end
        if ($urandom_range(19) == 0) begin
            it.action = ACT_PIXEL;
            return it;
        end
        if (!starving && $urandom_range(199) == 0) begin
            starving = 1'b1;
        end
        if (!lp_held_valid && !starving && $urandom_range(3) == 0) begin
            if (pixels_left == 0) begin
                pixels_left = $urandom_range(4, 1);
            end
            pixels_left   = pixels_left - 1;
            it.action     = ACT_PIXEL;
            it.last_pixel = (pixels_left == 0);
        end
        return it;
    endfunction

    function automatic void note_fault(input string msg);
        fault_count = fault_count + 1;
        if (fault_count <= MAX_REPORTS) begin
            $display("mismatch: %s", msg);
        end
    endfunction

    always @(posedge clk) begin : check_side
        rlps_pkg::t_out_item want;
        t_given              g;
        if (rst_n) begin
            if (in_valid && !in_stall) begin
                want = advance_line(in_data);
                g    = given_expect.pop_front();
                line_expect.push_back(g.typed ? g.want : want);
            end
            if (out_valid && !out_stall) begin
                result_seq = result_seq + 1;
                if (line_expect.size() == 0) begin
                    note_fault($sformatf("result %0d lvl/acc/ref/und/done=%b, none expected",
                                         result_seq, out_data));
                end else begin
                    want = line_expect.pop_front();
                    if (want !== out_data) begin
                        note_fault($sformatf("result %0d lvl/acc/ref/und/done exp %b got %b",
                                             result_seq, want, out_data));
                    end
                end
            end
        end
    end

    always @(posedge clk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // result side: random stall, with a long hold-off on request
    initial begin : result_side
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                out_stall <= 1'b1;
            end else begin
                out_stall <= ($urandom_range(99) < recv_pct);
            end
        end
    end

    task automatic push_line_item(input rlps_pkg::t_in_item it, input logic typed,
                                  input rlps_pkg::t_out_item want);
        while ($urandom_range(99) < send_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        given_expect.push_back('{typed, want});
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (line_expect.size() != 0) begin
            @(negedge clk);
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= rlps_pkg::CFG_DATA_WIDTH'(val);
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        case (idx)
            rlps_pkg::REG_BIT_PERIOD:     lp_cfg.bit_period     = val;
            rlps_pkg::REG_HIGH_TIME_ONE:  lp_cfg.high_time_one  = val;
            rlps_pkg::REG_HIGH_TIME_ZERO: lp_cfg.high_time_zero = val;
            rlps_pkg::REG_TRAILER_BITS:   lp_cfg.trailer_bits   = val;
            default: ;
        endcase
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata[7:0] !== val) begin
            note_fault($sformatf("register %0d read exp %h got %h", idx, val, prdata[7:0]));
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    task automatic run_phase(input rlps_pkg::t_cfg c, input int n, input t_idle_mode m,
                             input bit hold, input bit pause);
        drain_results();
        write_reg(rlps_pkg::REG_BIT_PERIOD, c.bit_period);
        write_reg(rlps_pkg::REG_HIGH_TIME_ONE, c.high_time_one);
        write_reg(rlps_pkg::REG_HIGH_TIME_ZERO, c.high_time_zero);
        write_reg(rlps_pkg::REG_TRAILER_BITS, c.trailer_bits);
        send_pct = (m == IDLE_SEND) ? 64 : (m == IDLE_BOTH) ? 31 : 0;
        recv_pct = (m == IDLE_RECV) ? 64 : (m == IDLE_BOTH) ? 31 : 0;
        for (int i = 0; i < n; i++) begin
            if (i == n / 2 && hold) begin
                hold_request = 1'b1;
            end
            if (i == n / 2 && pause) begin
                drain_results();
            end
            push_line_item(pick_item(), 1'b0, '0);
        end
    endtask

    initial begin
        reset_line();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int r = 0; r < DIR_ROWS; r++) begin
            push_line_item(DIRECTED[r].item, DIRECTED[r].typed, DIRECTED[r].want);
        end

        // period changes land mid-bit since the line is never drained between phases
        run_phase('{8'd2,   8'd1,   8'd0,   8'd0},   300, IDLE_NONE, 1'b0, 1'b0);
        run_phase('{8'd3,   8'd2,   8'd1,   8'd2},   300, IDLE_SEND, 1'b0, 1'b1);
        run_phase('{8'd0,   8'd255, 8'd0,   8'd1},   300, IDLE_RECV, 1'b0, 1'b0);
        run_phase('{8'd1,   8'd1,   8'd255, 8'd255}, 300, IDLE_BOTH, 1'b0, 1'b0);
        run_phase('{8'd4,   8'd3,   8'd1,   8'd3},   300, IDLE_NONE, 1'b1, 1'b0);
        run_phase('{8'd255, 8'd200, 8'd255, 8'd1},   300, IDLE_NONE, 1'b0, 1'b0);
        run_phase('{8'd2,   8'd0,   8'd2,   8'd5},   300, IDLE_BOTH, 1'b0, 1'b0);

        drain_results();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (fault_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
